/* hdl/touch_primary_contact_tracker_defines.svh */
// assertion macros shared by the tracker rtl
`ifndef TOUCH_PRIMARY_CONTACT_TRACKER_DEFINES_SVH
`define TOUCH_PRIMARY_CONTACT_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define TPCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define TPCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TPCT_ASSERT_IMP(lbl, ante, cons, msg)
`define TPCT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/tpct_pkg.sv */
// types and constants of the touch contact tracker
package tpct_pkg;

  localparam int unsigned RAW_W    = 16;
  localparam int unsigned NUM_W    = 12;
  localparam int unsigned DEN_W    = 16;
  localparam int unsigned PROD_W   = RAW_W + NUM_W;
  localparam int unsigned STEP_W   = $clog2(PROD_W + 1);
  localparam int unsigned POINT_W  = 16;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned SEEN_W   = 3;

  localparam logic [1:0] ACT_IDLE     = 2'd0;
  localparam logic [1:0] ACT_FAILED   = 2'd1;
  localparam logic [1:0] ACT_RELEASED = 2'd2;
  localparam logic [1:0] ACT_CONTACTS = 2'd3;

  localparam logic [1:0] REG_DISPLAY_WIDTH  = 2'd0;
  localparam logic [1:0] REG_DISPLAY_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PANEL_WIDTH    = 2'd2;
  localparam logic [1:0] REG_PANEL_HEIGHT   = 2'd3;

  localparam logic [NUM_W-1:0] DISPLAY_WIDTH_RST  = 12'd800;
  localparam logic [NUM_W-1:0] DISPLAY_HEIGHT_RST = 12'd480;
  localparam logic [DEN_W-1:0] PANEL_WIDTH_RST    = 16'd800;
  localparam logic [DEN_W-1:0] PANEL_HEIGHT_RST   = 16'd480;

  localparam logic [SEEN_W-1:0] MAX_CONTACTS = 3'd5;

  typedef struct packed {
    logic [1:0]       action;
    logic             has_contact;
    logic [ID_W-1:0]  contact_id;
    logic [RAW_W-1:0] contact_x;
    logic [RAW_W-1:0] contact_y;
    logic             last_of_poll;
  } item_t;

  typedef struct packed {
    logic               pressed;
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;
    logic [COUNT_W-1:0] idle_count;
    logic [COUNT_W-1:0] fail_count;
    logic [COUNT_W-1:0] buffer_count;
  } result_t;

endpackage

/* hdl/tpct_stream_if.sv */
// valid/ready stream interface carrying one payload per transfer
interface tpct_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/touch_primary_contact_tracker.sv */
// top level of the touch primary contact tracker
// Follows one primary finger across touch polls. A poll is a run of items on item_i ended by
// last_of_poll; each run gives exactly one transfer on result_o carrying the pressed state,
// the scaled point and three wrapping poll counters. Items are taken one per cycle unless
// scaling runs or a held result blocks them. An item that takes a new point (the tracked
// contact found, or a first contact adopted) starts both bit-serial scalers, x and y side by
// side; each runs a shift-add multiply, then a restoring divide, and item_i stays stalled
// until both are done. If it ends the poll, the result follows the scaling. The result waits
// in an output register and the next item is taken as it drains. Scaling saturates at
// 2^COORD_BITS - 1, also for a zero panel size. Size registers sit on the APB port at byte
// addresses 0, 4, 8 and 12, to be written only while the block is idle; it does not check.
`include "touch_primary_contact_tracker_defines.svh"
module touch_primary_contact_tracker #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tpct_stream_if.sink                       item_i,
  tpct_stream_if.source                     result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tpct_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [tpct_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tpct_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import tpct_pkg::*;

  logic [NUM_W-1:0]      disp_w_q, disp_w_d, disp_h_q, disp_h_d;
  logic [DEN_W-1:0]      pan_w_q, pan_w_d, pan_h_q, pan_h_d;
  logic                  pressed_q, pressed_d;
  logic [COORD_BITS-1:0] lat_x_q, lat_x_d, lat_y_q, lat_y_d;
  logic                  primary_valid_q, primary_valid_d;
  logic [ID_W-1:0]       track_q, track_d;
  logic                  wait_clr_q, wait_clr_d;
  logic                  in_poll_q, in_poll_d;
  logic                  decided_q, decided_d;
  logic                  tracking_q, tracking_d;
  logic [1:0]            run_act_q, run_act_d;
  logic [SEEN_W-1:0]     seen_q, seen_d;
  logic [COUNT_W-1:0]    idle_q, idle_d, fail_q, fail_d, buf_q, buf_d;
  logic                  busy_q, busy_d;
  logic                  pend_q, pend_d;
  logic                  res_valid_q, res_valid_d;
  result_t               res_q, res_d;
  logic                  item_acc;
  logic                  scale_start;
  logic                  emit;
  logic                  done_x, done_y;
  logic [COORD_BITS-1:0] scaled_x, scaled_y;
  logic                  apb_we;

  assign item_acc       = item_i.valid && item_i.ready;
  assign item_i.ready   = !busy_q && (!res_valid_q || result_o.ready);
  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;
  assign pready         = 1'b1;
  assign apb_we         = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_DISPLAY_WIDTH:  prdata = APB_DATA_W'(disp_w_q);
      REG_DISPLAY_HEIGHT: prdata = APB_DATA_W'(disp_h_q);
      REG_PANEL_WIDTH:    prdata = APB_DATA_W'(pan_w_q);
      REG_PANEL_HEIGHT:   prdata = APB_DATA_W'(pan_h_q);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    disp_w_d = disp_w_q;
    disp_h_d = disp_h_q;
    pan_w_d  = pan_w_q;
    pan_h_d  = pan_h_q;
    if (apb_we) begin
      case (paddr[3:2])
        REG_DISPLAY_WIDTH:  disp_w_d = pwdata[NUM_W-1:0];
        REG_DISPLAY_HEIGHT: disp_h_d = pwdata[NUM_W-1:0];
        REG_PANEL_WIDTH:    pan_w_d  = pwdata[DEN_W-1:0];
        REG_PANEL_HEIGHT:   pan_h_d  = pwdata[DEN_W-1:0];
        default: ;
      endcase
    end
  end

  tpct_scale #(.COORD_BITS(COORD_BITS)) u_scale_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scale_start),
    .raw_i    (item_i.data.contact_x),
    .num_i    (disp_w_q),
    .den_i    (pan_w_q),
    .done_o   (done_x),
    .result_o (scaled_x)
  );

  tpct_scale #(.COORD_BITS(COORD_BITS)) u_scale_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scale_start),
    .raw_i    (item_i.data.contact_y),
    .num_i    (disp_h_q),
    .den_i    (pan_h_q),
    .done_o   (done_y),
    .result_o (scaled_y)
  );

  always_comb begin
    logic              first;
    logic [1:0]        act;
    logic              cur_tracking;
    logic              cur_decided;
    logic [SEEN_W-1:0] cur_seen;

    first           = !in_poll_q;
    act             = first ? item_i.data.action : run_act_q;
    cur_tracking    = first ? primary_valid_q : tracking_q;
    cur_decided     = first ? 1'b0 : decided_q;
    cur_seen        = first ? '0 : seen_q;
    pressed_d       = pressed_q;
    lat_x_d         = lat_x_q;
    lat_y_d         = lat_y_q;
    primary_valid_d = primary_valid_q;
    track_d         = track_q;
    wait_clr_d      = wait_clr_q;
    in_poll_d       = in_poll_q;
    decided_d       = decided_q;
    tracking_d      = tracking_q;
    run_act_d       = run_act_q;
    seen_d          = seen_q;
    idle_d          = idle_q;
    fail_d          = fail_q;
    buf_d           = buf_q;
    busy_d          = busy_q;
    pend_d          = pend_q;
    scale_start     = 1'b0;
    emit            = 1'b0;

    if (item_acc) begin
      if (first) begin
        in_poll_d  = 1'b1;
        run_act_d  = item_i.data.action;
        seen_d     = '0;
        decided_d  = 1'b0;
        tracking_d = primary_valid_q;
        case (item_i.data.action)
          ACT_IDLE:   idle_d = idle_q + 1'b1;
          ACT_FAILED: fail_d = fail_q + 1'b1;
          ACT_RELEASED: begin
            buf_d           = buf_q + 1'b1;
            pressed_d       = 1'b0;
            primary_valid_d = 1'b0;
            wait_clr_d      = 1'b0;
          end
          ACT_CONTACTS: buf_d = buf_q + 1'b1;
          default: ;
        endcase
      end
      if (act == ACT_CONTACTS && item_i.data.has_contact && cur_seen < MAX_CONTACTS) begin
        seen_d = cur_seen + 1'b1;
        if (!cur_decided) begin
          if (cur_tracking) begin
            if (item_i.data.contact_id == track_q) begin
              scale_start = 1'b1;
              decided_d   = 1'b1;
            end
          end else if (!wait_clr_d) begin
            // adopt the first contact as primary
            track_d         = item_i.data.contact_id;
            primary_valid_d = 1'b1;
            pressed_d       = 1'b1;
            scale_start     = 1'b1;
            decided_d       = 1'b1;
          end
        end
      end
      if (item_i.data.last_of_poll) begin
        if (act == ACT_CONTACTS && cur_tracking && !decided_d) begin
          // tracked finger gone: release and wait for a clear panel
          pressed_d       = 1'b0;
          primary_valid_d = 1'b0;
          wait_clr_d      = 1'b1;
        end
        in_poll_d = 1'b0;
        if (scale_start) begin
          pend_d = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      if (scale_start) begin
        busy_d = 1'b1;
      end
    end

    if (done_x) begin
      busy_d  = 1'b0;
      lat_x_d = scaled_x;
      lat_y_d = scaled_y;
      if (pend_q) begin
        emit   = 1'b1;
        pend_d = 1'b0;
      end
    end

    res_d              = res_q;
    res_d.pressed      = pressed_d;
    res_d.point_x      = POINT_W'(lat_x_d);
    res_d.point_y      = POINT_W'(lat_y_d);
    res_d.idle_count   = idle_d;
    res_d.fail_count   = fail_d;
    res_d.buffer_count = buf_d;
    if (!emit) begin
      res_d = res_q;
    end

    if (emit) begin
      res_valid_d = 1'b1;
    end else if (res_valid_q && !result_o.ready) begin
      res_valid_d = 1'b1;
    end else begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_w_q        <= DISPLAY_WIDTH_RST;
      disp_h_q        <= DISPLAY_HEIGHT_RST;
      pan_w_q         <= PANEL_WIDTH_RST;
      pan_h_q         <= PANEL_HEIGHT_RST;
      pressed_q       <= 1'b0;
      lat_x_q         <= '0;
      lat_y_q         <= '0;
      primary_valid_q <= 1'b0;
      track_q         <= '0;
      wait_clr_q      <= 1'b0;
      in_poll_q       <= 1'b0;
      decided_q       <= 1'b0;
      tracking_q      <= 1'b0;
      run_act_q       <= ACT_IDLE;
      seen_q          <= '0;
      idle_q          <= '0;
      fail_q          <= '0;
      buf_q           <= '0;
      busy_q          <= 1'b0;
      pend_q          <= 1'b0;
      res_valid_q     <= 1'b0;
    end else begin
      disp_w_q        <= disp_w_d;
      disp_h_q        <= disp_h_d;
      pan_w_q         <= pan_w_d;
      pan_h_q         <= pan_h_d;
      pressed_q       <= pressed_d;
      lat_x_q         <= lat_x_d;
      lat_y_q         <= lat_y_d;
      primary_valid_q <= primary_valid_d;
      track_q         <= track_d;
      wait_clr_q      <= wait_clr_d;
      in_poll_q       <= in_poll_d;
      decided_q       <= decided_d;
      tracking_q      <= tracking_d;
      run_act_q       <= run_act_d;
      seen_q          <= seen_d;
      idle_q          <= idle_d;
      fail_q          <= fail_d;
      buf_q           <= buf_d;
      busy_q          <= busy_d;
      pend_q          <= pend_d;
      res_valid_q     <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  `TPCT_ASSERT_IMP(a_pressed_primary, pressed_q, primary_valid_q, "pressed with no primary")
  `TPCT_ASSERT_IMP(a_wait_no_primary, wait_clr_q, !primary_valid_q, "waiting while tracking")
  `TPCT_ASSERT_IMP(a_lanes_in_step, done_x, done_y && busy_q, "x and y scalers out of step")
  `TPCT_ASSERT_IMP(a_pend_busy, pend_q, busy_q && !in_poll_q, "result pending with no scaling")

endmodule

/* hdl/tpct_scale.sv */
// bit-serial scaler: raw * num / den, saturating
`include "touch_primary_contact_tracker_defines.svh"
module tpct_scale #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tpct_pkg::RAW_W-1:0]   raw_i,
  input  logic [tpct_pkg::NUM_W-1:0]   num_i,
  input  logic [tpct_pkg::DEN_W-1:0]   den_i,
  output logic                         done_o,
  output logic [COORD_BITS-1:0]        result_o
);
  import tpct_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [STEP_W-1:0]     cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [NUM_W-1:0]      num_q, num_d;
  logic [RAW_W-1:0]      raw_q, raw_d;
  logic [DEN_W-1:0]      den_q, den_d;
  logic [PROD_W-1:0]     acc_q, acc_d;
  logic [DEN_W-1:0]      rem_q, rem_d;
  logic [COORD_BITS-1:0] quo_q, quo_d;
  logic                  ovf_q, ovf_d;
  logic [DEN_W:0]        trial;
  logic [DEN_W:0]        diff;
  logic                  fits;

  assign trial = {rem_q, acc_q[PROD_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    num_d   = num_q;
    raw_d   = raw_q;
    den_d   = den_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_MUL;
          cnt_d   = STEP_W'(NUM_W);
          num_d   = num_i;
          raw_d   = raw_i;
          den_d   = den_i;
          acc_d   = '0;
          rem_d   = '0;
          quo_d   = '0;
          ovf_d   = 1'b0;
        end
      end
      ST_MUL: begin
        // one multiplier bit per cycle, msb first
        acc_d = {acc_q[PROD_W-2:0], 1'b0} + (num_q[NUM_W-1] ? PROD_W'(raw_q) : '0);
        num_d = {num_q[NUM_W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          state_d = ST_DIV;
          cnt_d   = STEP_W'(PROD_W);
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        acc_d = {acc_q[PROD_W-2:0], 1'b0};
        rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_d = {quo_q[COORD_BITS-2:0], fits};
        ovf_d = ovf_q | quo_q[COORD_BITS-1];
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    raw_q <= raw_d;
    den_q <= den_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign done_o   = done_q;
  assign result_o = ovf_q ? '1 : quo_q;

  `TPCT_ASSERT_IMP(a_start_when_idle, start_i, state_q == ST_IDLE, "scaler started while busy")
  `TPCT_ASSERT_NXT(a_done_single, done_q, !done_q, "scaler done held longer than a cycle")
  `TPCT_ASSERT_IMP(a_steps_left, state_q != ST_IDLE, cnt_q != '0, "scaler running with no steps left")

endmodule
